### sv/wcrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and the CRC-8 byte update for the word framer and checker.
package wcrc_pkg;

    typedef enum logic [1:0] {
        KIND_RX   = 2'd0,
        KIND_CMD  = 2'd1,
        KIND_ARG  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        POS_HIGH = 2'd0,
        POS_LOW  = 2'd1,
        POS_CRC  = 2'd2
    } rx_pos_t;

    localparam logic [1:0] CFG_POLY  = 2'd0;
    localparam logic [1:0] CFG_INIT  = 2'd1;
    localparam logic [1:0] CFG_WORDS = 2'd2;

    localparam logic [7:0] POLY_RESET  = 8'h31;
    localparam logic [7:0] INIT_RESET  = 8'hFF;
    localparam logic [4:0] WORDS_RESET = 5'd1;

    localparam int TX_LAST_CMD = 1;
    localparam int TX_LAST_ARG = 2;

    typedef struct packed {
        logic        valid;
        logic [15:0] word;
        logic        word_ok;
        logic        crc_err;
        logic        last;
    } rx_result_t;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc_in,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### sv/wcrc_rx.sv
`timescale 1ns / 1ps
`default_nettype none
// Receive side: triple tracking, CRC check and frame word counting.
module wcrc_rx
    import wcrc_pkg::*;
#(
    parameter int MAX_WORDS = 16
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        commit,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_start,
    input  wire logic [7:0]  crc_polynomial,
    input  wire logic [7:0]  crc_initial,
    input  wire logic [4:0]  words_expected,
    output rx_result_t       res
);

    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;

    rx_pos_t            pos_reg, pos_next, pos_eff;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, cnt_eff, cnt_inc, limit;
    logic               failed_reg, failed_next, failed_eff;
    logic [7:0]         high_reg, low_reg;
    logic [7:0]         partial_reg;
    logic [LIM_W-1:0]   we_ext, lim_full;
    logic [7:0]         crc_calc;
    logic               blocked, match;

    always_comb
    begin
        we_ext = LIM_W'(words_expected);
        if (we_ext == '0)
        begin
            lim_full = LIM_W'(1);
        end
        else if (we_ext > LIM_W'(MAX_WORDS))
        begin
            lim_full = LIM_W'(MAX_WORDS);
        end
        else
        begin
            lim_full = we_ext;
        end
        limit = lim_full[CNT_W-1:0];
    end

    always_comb
    begin
        pos_eff     = frame_start ? POS_HIGH : pos_reg;
        cnt_eff     = frame_start ? '0 : cnt_reg;
        failed_eff  = frame_start ? 1'b0 : failed_reg;
        blocked     = failed_eff || (cnt_eff >= limit);
        crc_calc    = crc_feed(partial_reg, low_reg, crc_polynomial);
        match       = (crc_calc == rx_byte);
        cnt_inc     = cnt_eff + CNT_W'(1);

        res.valid   = !blocked && (pos_eff == POS_CRC);
        res.word    = match ? {high_reg, low_reg} : 16'h0000;
        res.word_ok = match;
        res.crc_err = !match;
        res.last    = match && (cnt_inc >= limit);

        pos_next    = pos_eff;
        if (!blocked)
        begin
            unique case (pos_eff)
                POS_HIGH: pos_next = POS_LOW;
                POS_LOW:  pos_next = POS_CRC;
                POS_CRC:  pos_next = POS_HIGH;
                default:  pos_next = POS_HIGH;
            endcase
        end
        cnt_next    = (res.valid && match) ? cnt_inc : cnt_eff;
        failed_next = failed_eff || (res.valid && !match);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_HIGH;
            cnt_reg    <= '0;
            failed_reg <= 1'b0;
            high_reg   <= 8'h00;
            low_reg    <= 8'h00;
        end
        else if (commit)
        begin
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            failed_reg <= failed_next;
            if (!blocked && pos_eff == POS_HIGH)
            begin
                high_reg <= rx_byte;
            end
            if (!blocked && pos_eff == POS_LOW)
            begin
                low_reg <= rx_byte;
            end
        end
    end

    // track the CRC over the stored high byte under the current settings
    always_ff @(posedge clk)
    begin
        partial_reg <= crc_feed(crc_initial, high_reg, crc_polynomial);
    end

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_WORDS))
        else $error("word count past frame maximum");

    a_no_count_after_fail: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg && !(commit && frame_start) |=> cnt_reg == $past(cnt_reg))
        else $error("word counted after CRC failure");

    a_pos_legal: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg == POS_HIGH || pos_reg == POS_LOW || pos_reg == POS_CRC)
        else $error("triple position out of range");

endmodule
`default_nettype wire

### sv/word_crc8_framer_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the CRC-8 word framer and checker.
//
// Input channel (in_valid/in_ready) takes one word per handshake: a received
// byte (kind 0, with frame_start), a command word to send (kind 1) or an
// argument word to send (kind 2). Kind 3 is dropped.
// Output channel (out_valid/out_ready) gives one result word per handshake:
// a transmit byte (high, low, then CRC for arguments) or a checked receive word.
// Configuration channel (cfg_valid/cfg_ready) writes polynomial, initial value
// and expected word count; write only while idle. The cycle after a write the
// input channel is held off.
// The first result of a word passes from the input register to the result
// register and then to the output register. The result register gives one output
// word per cycle while the output register is free; a command word occupies it for
// its high and low bytes, an argument word for high, low and CRC, a receive byte
// for at most one word. Receive bytes with no result bypass the result register.
// Reset clears all pipeline valids, the receive frame state and the registers
// to polynomial 0x31, initial 0xFF, one word per frame.
// A stalled receiver holds the output register; the pipeline fills behind it
// and in_ready drops once the input register is full.
module word_crc8_framer_checker
    import wcrc_pkg::*;
#(
    parameter int MAX_WORDS = 16
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [15:0] tx_word,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic [15:0]      word_out,
    output logic             word_valid,
    output logic             crc_error,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic [7:0]  poly_reg, init_reg;
    logic [4:0]  words_reg;
    logic        cfg_fresh_reg;

    logic        s1_valid_reg, s1_valid_next;
    kind_t       s1_kind_reg;
    logic [7:0]  s1_rx_byte_reg;
    logic [15:0] s1_tx_word_reg;
    logic        s1_fs_reg;

    logic        s2_valid_reg, s2_valid_next;
    logic        s2_tx_reg;
    logic [1:0]  s2_idx_reg, s2_idx_next, s2_lastidx_reg;
    logic [7:0]  s2_hi_reg, s2_lo_reg, s2_crc_reg;
    logic [15:0] s2_word_reg;
    logic        s2_word_ok_reg, s2_crc_err_reg, s2_last_reg;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        byte_valid_reg, byte_valid_next;
    logic [15:0] word_out_reg, word_out_next;
    logic        word_valid_reg, word_valid_next;
    logic        crc_error_reg, crc_error_next;
    logic        last_reg, last_next;

    rx_result_t  rx_res;
    logic        in_acc, cfg_acc;
    logic        s1_is_tx, s1_has_result, s1_go, s1_load_s2;
    logic        o_free, s2_emit, s2_done, s2_free;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= POLY_RESET;
            init_reg      <= INIT_RESET;
            words_reg     <= WORDS_RESET;
            cfg_fresh_reg <= 1'b0;
        end
        else
        begin
            cfg_fresh_reg <= cfg_acc;
            if (cfg_acc)
            begin
                unique case (cfg_index)
                    CFG_POLY:  poly_reg  <= cfg_data;
                    CFG_INIT:  init_reg  <= cfg_data;
                    CFG_WORDS: words_reg <= cfg_data[4:0];
                    default:   ;
                endcase
            end
        end
    end

    wcrc_rx #(
        .MAX_WORDS (MAX_WORDS)
    ) u_rx (
        .clk            (clk),
        .rst_n          (rst_n),
        .commit         (s1_go && s1_kind_reg == KIND_RX),
        .rx_byte        (s1_rx_byte_reg),
        .frame_start    (s1_fs_reg),
        .crc_polynomial (poly_reg),
        .crc_initial    (init_reg),
        .words_expected (words_reg),
        .res            (rx_res)
    );

    always_comb
    begin
        o_free        = !out_valid_reg || out_ready;
        s2_emit       = s2_valid_reg && o_free;
        s2_done       = s2_emit && (s2_idx_reg == s2_lastidx_reg);
        s2_free       = !s2_valid_reg || s2_done;
        s1_is_tx      = (s1_kind_reg == KIND_CMD) || (s1_kind_reg == KIND_ARG);
        s1_has_result = s1_is_tx || (s1_kind_reg == KIND_RX && rx_res.valid);
        s1_go         = s1_valid_reg && (!s1_has_result || s2_free);
        s1_load_s2    = s1_go && s1_has_result;
        in_ready      = !cfg_fresh_reg && (!s1_valid_reg || s1_go);
        in_acc        = in_valid && in_ready;
        s1_valid_next = in_acc || (s1_valid_reg && !s1_go);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_kind_reg    <= kind_t'(kind);
            s1_rx_byte_reg <= rx_byte;
            s1_tx_word_reg <= tx_word;
            s1_fs_reg      <= frame_start;
        end
    end

    always_comb
    begin
        s2_valid_next = s1_load_s2 || (s2_valid_reg && !s2_done);
        s2_idx_next   = s1_load_s2 ? 2'd0 : (s2_emit ? s2_idx_reg + 2'd1 : s2_idx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_idx_reg   <= 2'd0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s2_idx_reg   <= s2_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load_s2)
        begin
            s2_tx_reg      <= s1_is_tx;
            s2_lastidx_reg <= (s1_kind_reg == KIND_CMD) ? 2'(TX_LAST_CMD)
                            : (s1_kind_reg == KIND_ARG) ? 2'(TX_LAST_ARG) : 2'd0;
            s2_hi_reg      <= s1_tx_word_reg[15:8];
            s2_lo_reg      <= s1_tx_word_reg[7:0];
            s2_crc_reg     <= crc_feed(init_reg, s1_tx_word_reg[15:8], poly_reg);
            s2_word_reg    <= rx_res.word;
            s2_word_ok_reg <= rx_res.word_ok;
            s2_crc_err_reg <= rx_res.crc_err;
            s2_last_reg    <= rx_res.last;
        end
    end

    always_comb
    begin
        out_valid_next = s2_emit || (out_valid_reg && !out_ready);
        if (s2_tx_reg)
        begin
            unique case (s2_idx_reg)
                2'd0:    out_byte_next = s2_hi_reg;
                2'd1:    out_byte_next = s2_lo_reg;
                default: out_byte_next = crc_feed(s2_crc_reg, s2_lo_reg, poly_reg);
            endcase
            byte_valid_next = 1'b1;
            word_out_next   = 16'h0000;
            word_valid_next = 1'b0;
            crc_error_next  = 1'b0;
            last_next       = (s2_idx_reg == s2_lastidx_reg);
        end
        else
        begin
            out_byte_next   = 8'h00;
            byte_valid_next = 1'b0;
            word_out_next   = s2_word_reg;
            word_valid_next = s2_word_ok_reg;
            crc_error_next  = s2_crc_err_reg;
            last_next       = s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_emit)
        begin
            out_byte_reg   <= out_byte_next;
            byte_valid_reg <= byte_valid_next;
            word_out_reg   <= word_out_next;
            word_valid_reg <= word_valid_next;
            crc_error_reg  <= crc_error_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign word_out   = word_out_reg;
    assign word_valid = word_valid_reg;
    assign crc_error  = crc_error_reg;
    assign last       = last_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> s2_idx_reg <= s2_lastidx_reg)
        else $error("result index beyond last result of word");

    a_one_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot({byte_valid_reg, word_valid_reg, crc_error_reg}))
        else $error("output word carries no single result kind");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && crc_error_reg |-> !last_reg && word_out_reg == 16'h0000)
        else $error("CRC error result carries data or last");

    a_cfg_gap: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_acc |=> !in_ready)
        else $error("input taken straight after a register write");

endmodule
`default_nettype wire
